>>> hw/rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_STOP  = 3'd1;
    localparam logic [2:0] MODE_SEND  = 3'd2;
    localparam logic [2:0] MODE_WACK  = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_SEND,
        CMD_WACK,
        CMD_READ
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_entry_t;

endpackage

>>> hw/rtl/i2cm_if.sv
// Valid/ready channel interfaces for ticks and per-tick results.
`timescale 1ns / 1ps

interface i2cm_tick_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (
        output valid, cmd_valid, mode, tx_byte, send_ack, sda_in,
        input  ready
    );
    modport sink (
        input  valid, cmd_valid, mode, tx_byte, send_ack, sda_in,
        output ready
    );
endinterface

interface i2cm_result_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;

    modport source (
        output valid, scl_level, sda_level, sda_drive, busy_res, done_res, rx_byte,
               ack_failed,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_level, sda_drive, busy_res, done_res, rx_byte,
               ack_failed,
        output ready
    );
endinterface

>>> hw/rtl/i2c_master_bit_engine.sv
// I2C master bit engine top level: tick queue front end feeding the bus engine.
// A tick passes through two register stages, tick queue then engine state, before its result
// transaction is valid; a result that is not yet taken holds further ticks in the queue.
// Throughput: one tick per cycle while the result channel accepts each result.
// Reset: asynchronous active low; idle, SCL and SDA driven high, ack_timeout 250.
`timescale 1ns / 1ps

module i2c_master_bit_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_data,
    i2cm_tick_if.sink     tick,
    i2cm_result_if.source result
);

    logic                  q_valid;
    logic                  q_pop;
    i2cm_pkg::tick_entry_t q_data;

    i2cm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    i2cm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .result   (result)
    );

endmodule

>>> hw/rtl/i2cm_front.sv
// Tick intake: decodes the command field and queues ticks for the bus engine.
`timescale 1ns / 1ps

module i2cm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    i2cm_tick_if.sink            tick,
    output logic                 q_valid,
    output i2cm_pkg::tick_entry_t q_data,
    input  logic                 q_pop
);

    i2cm_pkg::tick_entry_t entry_reg [2];
    logic                  wr_ptr_reg;
    logic                  wr_ptr_next;
    logic                  rd_ptr_reg;
    logic                  rd_ptr_next;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic                  push;
    logic                  pop;
    i2cm_pkg::tick_entry_t decoded;

    always_comb
    begin
        decoded.tx_byte  = tick.tx_byte;
        decoded.send_ack = tick.send_ack;
        decoded.sda_in   = tick.sda_in;
        decoded.cmd      = i2cm_pkg::CMD_NONE;
        if (tick.cmd_valid)
        begin
            case (tick.mode)
                i2cm_pkg::MODE_START: decoded.cmd = i2cm_pkg::CMD_START;
                i2cm_pkg::MODE_STOP:  decoded.cmd = i2cm_pkg::CMD_STOP;
                i2cm_pkg::MODE_SEND:  decoded.cmd = i2cm_pkg::CMD_SEND;
                i2cm_pkg::MODE_WACK:  decoded.cmd = i2cm_pkg::CMD_WACK;
                i2cm_pkg::MODE_READ:  decoded.cmd = i2cm_pkg::CMD_READ;
                default:              decoded.cmd = i2cm_pkg::CMD_NONE;
            endcase
        end
    end

    assign tick.ready = (count_reg != 2'd2);
    assign push       = tick.valid && tick.ready;
    assign q_valid    = (count_reg != 2'd0);
    assign q_data     = entry_reg[rd_ptr_reg];
    assign pop        = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

>>> hw/rtl/i2cm_back.sv
// Bus engine: SCL/SDA sequencing per tick, with the state held as the result register.
`timescale 1ns / 1ps

module i2cm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_data,
    input  logic                  q_valid,
    input  i2cm_pkg::tick_entry_t q_data,
    output logic                  q_pop,
    i2cm_result_if.source         result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_STOP,
        ST_SEND,
        ST_WACK,
        ST_READ
    } state_t;

    state_t     state_reg,  state_next;
    logic [1:0] phase_reg,  phase_next;
    logic [3:0] bit_reg,    bit_next;
    logic [7:0] sh_reg,     sh_next;
    logic [7:0] wait_reg,   wait_next;
    logic       scl_reg,    scl_next;
    logic       sda_reg,    sda_next;
    logic       oe_reg,     oe_next;
    logic       choice_reg, choice_next;
    logic [7:0] rx_reg,     rx_next;
    logic       fail_reg,   fail_next;
    logic       done_reg,   done_next;
    logic       valid_reg,  valid_next;
    logic [7:0] timeout_reg;
    logic       pop;
    logic [3:0] bit_inc;

    assign pop     = q_valid && (!valid_reg || result.ready);
    assign q_pop   = pop;
    assign bit_inc = bit_reg + 4'd1;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        sh_next     = sh_reg;
        wait_next   = wait_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        oe_next     = oe_reg;
        choice_next = choice_reg;
        rx_next     = rx_reg;
        fail_next   = fail_reg;
        done_next   = done_reg;
        valid_next  = valid_reg && !result.ready;

        if (pop)
        begin
            valid_next = 1'b1;
            done_next  = 1'b0;
            if (state_reg == ST_IDLE)
            begin
                case (q_data.cmd)
                    i2cm_pkg::CMD_START:
                    begin
                        state_next = ST_START;
                        oe_next    = 1'b1;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        wait_next  = 8'd3;
                        phase_next = 2'd0;
                    end
                    i2cm_pkg::CMD_STOP:
                    begin
                        state_next = ST_STOP;
                        oe_next    = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        wait_next  = 8'd3;
                        phase_next = 2'd0;
                    end
                    i2cm_pkg::CMD_SEND:
                    begin
                        state_next = ST_SEND;
                        oe_next    = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = q_data.tx_byte[7];
                        sh_next    = {q_data.tx_byte[6:0], 1'b0};
                        bit_next   = 4'd0;
                        wait_next  = 8'd1;
                        phase_next = 2'd0;
                    end
                    i2cm_pkg::CMD_WACK:
                    begin
                        state_next = ST_WACK;
                        oe_next    = 1'b0;
                        sda_next   = 1'b1;
                        fail_next  = 1'b0;
                        wait_next  = 8'd0;
                        phase_next = 2'd0;
                    end
                    i2cm_pkg::CMD_READ:
                    begin
                        state_next  = ST_READ;
                        oe_next     = 1'b0;
                        scl_next    = 1'b0;
                        choice_next = q_data.send_ack;
                        sh_next     = 8'd0;
                        bit_next    = 4'd0;
                        wait_next   = 8'd1;
                        phase_next  = 2'd0;
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
            end
            else if (state_reg == ST_WACK && phase_reg == 2'd1)
            begin
                if (!q_data.sda_in)
                begin
                    scl_next   = 1'b0;
                    state_next = ST_IDLE;
                    phase_next = 2'd0;
                    done_next  = 1'b1;
                end
                else if (wait_reg >= timeout_reg)
                begin
                    fail_next  = 1'b1;
                    state_next = ST_STOP;
                    oe_next    = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    wait_next  = 8'd3;
                    phase_next = 2'd0;
                end
                else
                begin
                    wait_next = wait_reg + 8'd1;
                end
            end
            else if (wait_reg != 8'd0)
            begin
                wait_next = wait_reg - 8'd1;
            end
            else
            begin
                case (state_reg)
                    ST_START:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            sda_next   = 1'b0;
                            wait_next  = 8'd3;
                            phase_next = 2'd1;
                        end
                        else
                        begin
                            scl_next   = 1'b0;
                            state_next = ST_IDLE;
                            phase_next = 2'd0;
                            done_next  = 1'b1;
                        end
                    end
                    ST_STOP:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            wait_next  = 8'd3;
                            phase_next = 2'd1;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                            phase_next = 2'd0;
                            done_next  = 1'b1;
                        end
                    end
                    ST_SEND:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            scl_next   = 1'b1;
                            wait_next  = 8'd1;
                            phase_next = 2'd1;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            scl_next   = 1'b0;
                            wait_next  = 8'd1;
                            phase_next = 2'd2;
                        end
                        else
                        begin
                            bit_next = bit_inc;
                            if (bit_inc >= i2cm_pkg::BITS_PER_BYTE)
                            begin
                                state_next = ST_IDLE;
                                phase_next = 2'd0;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                sda_next   = sh_reg[7];
                                sh_next    = {sh_reg[6:0], 1'b0};
                                wait_next  = 8'd1;
                                phase_next = 2'd0;
                            end
                        end
                    end
                    ST_WACK:
                    begin
                        scl_next   = 1'b1;
                        wait_next  = 8'd0;
                        phase_next = 2'd1;
                    end
                    ST_READ:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            scl_next   = 1'b1;
                            sh_next    = {sh_reg[6:0], q_data.sda_in};
                            wait_next  = 8'd0;
                            phase_next = 2'd1;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            bit_next  = bit_inc;
                            scl_next  = 1'b0;
                            wait_next = 8'd1;
                            if (bit_inc < i2cm_pkg::BITS_PER_BYTE)
                            begin
                                phase_next = 2'd0;
                            end
                            else
                            begin
                                oe_next    = 1'b1;
                                sda_next   = ~choice_reg;
                                phase_next = 2'd2;
                            end
                        end
                        else if (phase_reg == 2'd2)
                        begin
                            scl_next   = 1'b1;
                            wait_next  = 8'd1;
                            phase_next = 2'd3;
                        end
                        else
                        begin
                            scl_next   = 1'b0;
                            rx_next    = sh_reg;
                            state_next = ST_IDLE;
                            phase_next = 2'd0;
                            done_next  = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 2'd0;
            bit_reg     <= 4'd0;
            sh_reg      <= 8'd0;
            wait_reg    <= 8'd0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            oe_reg      <= 1'b1;
            choice_reg  <= 1'b0;
            rx_reg      <= 8'd0;
            fail_reg    <= 1'b0;
            done_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            timeout_reg <= i2cm_pkg::ACK_TIMEOUT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            bit_reg     <= bit_next;
            sh_reg      <= sh_next;
            wait_reg    <= wait_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            oe_reg      <= oe_next;
            choice_reg  <= choice_next;
            rx_reg      <= rx_next;
            fail_reg    <= fail_next;
            done_reg    <= done_next;
            valid_reg   <= valid_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    assign result.valid      = valid_reg;
    assign result.scl_level  = scl_reg;
    assign result.sda_level  = sda_reg;
    assign result.sda_drive  = oe_reg;
    assign result.busy_res   = (state_reg != ST_IDLE);
    assign result.done_res   = done_reg;
    assign result.rx_byte    = rx_reg;
    assign result.ack_failed = fail_reg;

endmodule
